### design/plp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg
// shared types, constants and the trig table of the lidar packet parser
// ----------------------------------------------------------------------------
package plp_pkg;

  // packet framing
  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] INDEX_BASE  = 8'hA0;
  localparam logic [7:0] INDEX_LAST  = 8'hF9;
  localparam int         PACKET_LEN  = 22;
  localparam int         POS_W       = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);
  // index, speed word and four readings; the checksum is not kept
  localparam int         STORE_DEPTH = 19;
  localparam int         READINGS    = 4;

  // speed word / 384 = (word >> 7) / 3, and /3 as (v * 683) >> 11 for v < 512
  localparam logic [10:0] SPEED_RECIP = 11'd683;
  localparam int          SPEED_SHIFT = 11;

  // p / 1000 for p < 2**24 as (p * ceil(2**34 / 1000)) >> 34
  localparam logic [24:0] TRIG_RECIP = 25'd17179870;
  localparam int          TRIG_SHIFT = 34;

  localparam logic [9:0] DEG_FULL  = 10'd360;
  localparam logic [9:0] DEG_TWICE = 10'd720;
  localparam logic [9:0] DEG_QUART = 10'd90;
  localparam logic [8:0] ROT_RESET = 9'd270;

  // register map
  localparam logic REG_ROTATION = 1'b0;

  // trunc(1000 * sin(d)) for d = 0..90
  localparam logic [9:0] QUARTER_SINE [0:90] = '{
    10'd0,   10'd17,  10'd34,  10'd52,  10'd69,  10'd87,  10'd104, 10'd121, 10'd139, 10'd156,
    10'd173, 10'd190, 10'd207, 10'd224, 10'd241, 10'd258, 10'd275, 10'd292, 10'd309, 10'd325,
    10'd342, 10'd358, 10'd374, 10'd390, 10'd406, 10'd422, 10'd438, 10'd453, 10'd469, 10'd484,
    10'd500, 10'd515, 10'd529, 10'd544, 10'd559, 10'd573, 10'd587, 10'd601, 10'd615, 10'd629,
    10'd642, 10'd656, 10'd669, 10'd681, 10'd694, 10'd707, 10'd719, 10'd731, 10'd743, 10'd754,
    10'd766, 10'd777, 10'd788, 10'd798, 10'd809, 10'd819, 10'd829, 10'd838, 10'd848, 10'd857,
    10'd866, 10'd874, 10'd882, 10'd891, 10'd898, 10'd906, 10'd913, 10'd920, 10'd927, 10'd933,
    10'd939, 10'd945, 10'd951, 10'd956, 10'd961, 10'd965, 10'd970, 10'd974, 10'd978, 10'd981,
    10'd984, 10'd987, 10'd990, 10'd992, 10'd994, 10'd996, 10'd997, 10'd998, 10'd999, 10'd999,
    10'd1000
  };

  typedef struct packed {
    logic [7:0] dist_lo;
    logic [7:0] dist_hi;
    logic [7:0] str_lo;
    logic [7:0] str_hi;
  } reading_t;

  typedef struct packed {
    logic [6:0]                  sector;
    logic [7:0]                  speed;
    reading_t [READINGS-1:0]     rd;
  } packet_t;

  // sign and magnitude of a table value
  typedef struct packed {
    logic       neg;
    logic [9:0] mag;
  } trig_t;

  // a in 0..359
  function automatic trig_t sine_deg(input logic [8:0] a);
    trig_t      r;
    logic [8:0] d;
    if (a <= 9'd90) begin
      r.neg = 1'b0;
      d     = a;
    end else if (a <= 9'd180) begin
      r.neg = 1'b0;
      d     = 9'd180 - a;
    end else if (a <= 9'd270) begin
      r.neg = 1'b1;
      d     = a - 9'd180;
    end else begin
      r.neg = 1'b1;
      d     = 9'd360 - a;
    end
    r.mag = QUARTER_SINE[d[6:0]];
    return r;
  endfunction

  function automatic trig_t cosine_deg(input logic [8:0] a);
    logic [9:0] s;
    s = {1'b0, a} + DEG_QUART;
    if (s >= DEG_FULL) begin
      s = s - DEG_FULL;
    end
    return sine_deg(s[8:0]);
  endfunction

endpackage

### design/lidar_packet_to_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_to_points
// parses the byte stream of a spinning range sensor into x/y points
// ----------------------------------------------------------------------------
// input channel: one received byte per beat (in_valid / in_stall / rx_byte).
// the parser hunts for 0xfa, then collects 21 bytes; on the last byte of a
// packet with an index in 0xa0..0xf9 four reading beats follow on the output
// channel in slot order, the fourth marked by last_of_packet.
// throughput: one input byte per cycle unless in_stall holds it; the point pipe
// emits one reading per cycle while the receiver does not stall.
// latency: the closing byte loads the packet register, then each reading
// passes slot select and trig lookup, multiply and reciprocal divide, the
// other three following the first while the receiver does not stall.
// out_stall freezes the whole point pipe and holds the output beat; input
// bytes keep flowing until a packet closes while the previous one is still
// being emitted, then in_stall holds that closing byte.
// configuration: apb register 0 (rotation_deg) at byte address 0, to be
// written only while the block is idle; the user must keep to this, the
// block does not enforce it. pready is tied high. reset: synchronous, clears
// the framing counter, the pipe valids and sets the rotation to 270 degrees.
// ----------------------------------------------------------------------------
module lidar_packet_to_points (
  input  logic               clk,
  input  logic               rst,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  // reading output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         angle_deg,
  output logic [13:0]        distance,
  output logic               range_error,
  output logic               strength_warning,
  output logic [15:0]        signal_strength,
  output logic signed [14:0] pos_x,
  output logic signed [14:0] pos_y,
  output logic [7:0]         spin_speed,
  output logic               last_of_packet
);

  logic [8:0]       rotation_deg;
  logic             cfg_write;
  logic             pkt_load;
  logic             busy;
  plp_pkg::packet_t pkt;

  // register access; paddr[2] selects the register, addresses 4..7 are ignored
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == plp_pkg::REG_ROTATION);
  assign prdata    = (paddr[2] == plp_pkg::REG_ROTATION) ? 32'(rotation_deg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_deg <= plp_pkg::ROT_RESET;
    end else if (cfg_write) begin
      rotation_deg <= pwdata[8:0];
    end
  end

  // framing and packet store
  plp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .busy     (busy),
    .pkt_load (pkt_load),
    .pkt      (pkt)
  );

  // reading sequencer and x/y arithmetic
  plp_point_pipe u_point_pipe (
    .clk              (clk),
    .rst              (rst),
    .rotation_deg     (rotation_deg),
    .pkt_load         (pkt_load),
    .pkt              (pkt),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .angle_deg        (angle_deg),
    .distance         (distance),
    .range_error      (range_error),
    .strength_warning (strength_warning),
    .signal_strength  (signal_strength),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .spin_speed       (spin_speed),
    .last_of_packet   (last_of_packet)
  );

  // a new packet never overwrites one still being emitted
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    pkt_load |-> !busy)
    else $error("packet handed over while the previous one is in flight");

  // angles stay in range for every reading beat
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg < 9'd360))
    else $error("reading angle out of range");

  // a flagged reading carries no distance and sits at the origin
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (distance == '0 && pos_x == '0 && pos_y == '0))
    else $error("flagged reading with non-zero distance");

  // the packet marker sits on the fourth slot
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_packet) |-> (angle_deg[1:0] == 2'b11))
    else $error("last_of_packet on the wrong slot");

endmodule

### design/plp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_parser
// byte framing: hunts for the start byte, stores the packet, hands it over
// ----------------------------------------------------------------------------
module plp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic             busy,
  output logic             pkt_load,
  output plp_pkg::packet_t pkt
);

  logic [plp_pkg::POS_W-1:0] byte_position;
  logic [plp_pkg::POS_W-1:0] byte_position_next;
  logic [plp_pkg::POS_W-1:0] wr_pos;
  logic [7:0]                pkt_bytes [0:plp_pkg::STORE_DEPTH-1];
  logic                      accept;
  logic                      at_last;
  logic                      index_ok;
  logic [8:0]                speed_word;
  logic [19:0]               speed_prod;
  logic [7:0]                sector_full;

  assign at_last  = (byte_position == plp_pkg::LAST_POS);
  // the closing beat waits while the previous packet is still being emitted
  assign in_stall = at_last && busy;
  assign accept   = in_valid && !in_stall;
  assign wr_pos   = byte_position - plp_pkg::POS_W'(1);

  always_comb begin
    byte_position_next = byte_position;
    if (accept) begin
      if (byte_position == '0) begin
        if (rx_byte == plp_pkg::START_BYTE) begin
          byte_position_next = plp_pkg::POS_W'(1);
        end
      end else if (at_last) begin
        byte_position_next = '0;
      end else begin
        byte_position_next = byte_position + plp_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (byte_position != '0) &&
        (wr_pos < plp_pkg::POS_W'(plp_pkg::STORE_DEPTH))) begin
      pkt_bytes[wr_pos] <= rx_byte;
    end
  end

  assign index_ok = (pkt_bytes[0] >= plp_pkg::INDEX_BASE) &&
                    (pkt_bytes[0] <= plp_pkg::INDEX_LAST);
  assign pkt_load = accept && at_last && index_ok;

  // speed word >> 7, then divide by three
  assign speed_word  = {pkt_bytes[2], pkt_bytes[1][7]};
  assign speed_prod  = 20'(speed_word) * 20'(plp_pkg::SPEED_RECIP);
  assign sector_full = pkt_bytes[0] - plp_pkg::INDEX_BASE;

  always_comb begin
    pkt.sector = sector_full[6:0];
    pkt.speed  = speed_prod[plp_pkg::SPEED_SHIFT+7:plp_pkg::SPEED_SHIFT];
    for (int i = 0; i < plp_pkg::READINGS; i++) begin
      pkt.rd[i].dist_lo = pkt_bytes[3 + 4*i];
      pkt.rd[i].dist_hi = pkt_bytes[4 + 4*i];
      pkt.rd[i].str_lo  = pkt_bytes[5 + 4*i];
      pkt.rd[i].str_hi  = pkt_bytes[6 + 4*i];
    end
  end

endmodule

### design/plp_point_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_point_pipe
// emits the four readings of a packet and turns each into x and y
// ----------------------------------------------------------------------------
module plp_point_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic [8:0]         rotation_deg,
  input  logic               pkt_load,
  input  plp_pkg::packet_t   pkt,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         angle_deg,
  output logic [13:0]        distance,
  output logic               range_error,
  output logic               strength_warning,
  output logic [15:0]        signal_strength,
  output logic signed [14:0] pos_x,
  output logic signed [14:0] pos_y,
  output logic [7:0]         spin_speed,
  output logic               last_of_packet
);

  plp_pkg::packet_t cur;
  logic             pkt_valid;
  logic [1:0]       slot;
  logic             advance;

  // slot stage
  plp_pkg::reading_t rd0;
  logic [8:0]        angle0;
  logic              err0;
  logic [13:0]       dist0;
  logic [9:0]        look_sum;
  logic [9:0]        look;
  plp_pkg::trig_t    xt0;
  plp_pkg::trig_t    yt0;

  // trig stage
  logic           s1_valid;
  logic [8:0]     s1_angle;
  logic [13:0]    s1_dist;
  logic           s1_err;
  logic           s1_warn;
  logic [15:0]    s1_str;
  logic [7:0]     s1_speed;
  logic           s1_last;
  plp_pkg::trig_t s1_x;
  plp_pkg::trig_t s1_y;

  // product stage
  logic        s2_valid;
  logic [8:0]  s2_angle;
  logic [13:0] s2_dist;
  logic        s2_err;
  logic        s2_warn;
  logic [15:0] s2_str;
  logic [7:0]  s2_speed;
  logic        s2_last;
  logic        s2_x_neg;
  logic        s2_y_neg;
  logic [23:0] s2_px;
  logic [23:0] s2_py;

  logic [48:0] qx_full;
  logic [48:0] qy_full;
  logic [13:0] qx;
  logic [13:0] qy;

  assign advance = !out_valid || !out_stall;
  assign busy    = pkt_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      slot      <= '0;
    end else if (pkt_load) begin
      pkt_valid <= 1'b1;
      slot      <= '0;
    end else if (advance && pkt_valid) begin
      slot <= slot + 2'd1;
      if (slot == 2'd3) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_load) begin
      cur <= pkt;
    end
  end

  assign rd0      = cur.rd[slot];
  assign angle0   = {cur.sector, slot};
  assign err0     = rd0.dist_hi[7];
  assign dist0    = err0 ? 14'd0 : {rd0.dist_hi[5:0], rd0.dist_lo};
  assign look_sum = {1'b0, angle0} + {1'b0, rotation_deg};

  always_comb begin
    if (look_sum >= plp_pkg::DEG_TWICE) begin
      look = look_sum - plp_pkg::DEG_TWICE;
    end else if (look_sum >= plp_pkg::DEG_FULL) begin
      look = look_sum - plp_pkg::DEG_FULL;
    end else begin
      look = look_sum;
    end
  end

  assign xt0 = plp_pkg::cosine_deg(look[8:0]);
  assign yt0 = plp_pkg::sine_deg(look[8:0]);

  // control of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pkt_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_angle <= angle0;
      s1_dist  <= dist0;
      s1_err   <= err0;
      s1_warn  <= rd0.dist_hi[6];
      s1_str   <= {rd0.str_hi, rd0.str_lo};
      s1_speed <= cur.speed;
      s1_last  <= (slot == 2'd3);
      s1_x     <= xt0;
      s1_y     <= yt0;
    end
  end

  // distance times table magnitude
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_angle <= s1_angle;
      s2_dist  <= s1_dist;
      s2_err   <= s1_err;
      s2_warn  <= s1_warn;
      s2_str   <= s1_str;
      s2_speed <= s1_speed;
      s2_last  <= s1_last;
      s2_x_neg <= s1_x.neg;
      s2_y_neg <= s1_y.neg;
      s2_px    <= 24'(s1_dist) * 24'(s1_x.mag);
      s2_py    <= 24'(s1_dist) * 24'(s1_y.mag);
    end
  end

  // divide by 1000 on the magnitude, sign applied after: truncation toward zero
  assign qx_full = 49'(s2_px) * 49'(plp_pkg::TRIG_RECIP);
  assign qy_full = 49'(s2_py) * 49'(plp_pkg::TRIG_RECIP);
  assign qx      = qx_full[plp_pkg::TRIG_SHIFT+13:plp_pkg::TRIG_SHIFT];
  assign qy      = qy_full[plp_pkg::TRIG_SHIFT+13:plp_pkg::TRIG_SHIFT];

  always_ff @(posedge clk) begin
    if (advance) begin
      angle_deg        <= s2_angle;
      distance         <= s2_dist;
      range_error      <= s2_err;
      strength_warning <= s2_warn;
      signal_strength  <= s2_str;
      spin_speed       <= s2_speed;
      last_of_packet   <= s2_last;
      pos_x            <= s2_x_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      pos_y            <= s2_y_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
  end

endmodule

### test/lidar_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_checker
// watches the byte and reading channels and the register port of the packet
// parser, predicts every reading and compares it field by field
// ----------------------------------------------------------------------------
module lidar_packet_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [8:0]         angle_deg,
  input  logic [13:0]        distance,
  input  logic               range_error,
  input  logic               strength_warning,
  input  logic [15:0]        signal_strength,
  input  logic signed [14:0] pos_x,
  input  logic signed [14:0] pos_y,
  input  logic [7:0]         spin_speed,
  input  logic               last_of_packet,
  output int                 readings_pending,
  output int                 mismatches
);

  localparam int SPEED_DIV = 384;
  localparam int MILLI     = 1000;
  localparam int FULL_TURN = 360;

  typedef struct {
    logic [8:0]         angle;
    logic [13:0]        dist_mm;
    logic               err;
    logic               warn;
    logic [15:0]        strength;
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic [7:0]         speed;
    logic               last;
  } point_t;

  // trunc(1000 * sin(d)), d = 0..90
  int sin_milli [0:90] = '{
    0, 17, 34, 52, 69, 87, 104, 121, 139, 156,
    173, 190, 207, 224, 241, 258, 275, 292, 309, 325,
    342, 358, 374, 390, 406, 422, 438, 453, 469, 484,
    500, 515, 529, 544, 559, 573, 587, 601, 615, 629,
    642, 656, 669, 681, 694, 707, 719, 731, 743, 754,
    766, 777, 788, 798, 809, 819, 829, 838, 848, 857,
    866, 874, 882, 891, 898, 906, 913, 920, 927, 933,
    939, 945, 951, 956, 961, 965, 970, 974, 978, 981,
    984, 987, 990, 992, 994, 996, 997, 998, 999, 999,
    1000
  };

  point_t     points_due [$];
  logic [8:0] rotation;
  int         frame_pos;
  logic [7:0] frame [0:20];

  initial begin
    readings_pending = 0;
    mismatches       = 0;
    rotation         = plp_pkg::ROT_RESET;
    frame_pos        = 0;
  end

  function automatic int sine_of(input int a);
    if (a <= 90) return sin_milli[a];
    else if (a <= 180) return sin_milli[180 - a];
    else if (a <= 270) return -sin_milli[a - 180];
    else return -sin_milli[360 - a];
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // four readings from a closed frame with a valid index
  task automatic emit_points();
    int         speed, sector, mm, look, x, y, slot;
    logic [7:0] lo, hi;
    point_t     p;
    speed  = {frame[2], frame[1]} / SPEED_DIV;
    sector = frame[0] - plp_pkg::INDEX_BASE;
    for (slot = 0; slot < plp_pkg::READINGS; slot++) begin
      lo = frame[3 + slot * 4];
      hi = frame[4 + slot * 4];
      mm = hi[7] ? 0 : {hi[5:0], lo};
      p.angle    = 9'(sector * 4 + slot);
      p.dist_mm  = 14'(mm);
      p.err      = hi[7];
      p.warn     = hi[6];
      p.strength = {frame[6 + slot * 4], frame[5 + slot * 4]};
      look = (int'(p.angle) + int'(rotation)) % FULL_TURN;
      x = (mm * sine_of((look + 90) % FULL_TURN)) / MILLI;
      y = (mm * sine_of(look)) / MILLI;
      p.x     = 15'(x);
      p.y     = 15'(y);
      p.speed = 8'(speed);
      p.last  = (slot == plp_pkg::READINGS - 1);
      points_due.push_back(p);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (frame_pos == 0) begin
      // hunting: only the start byte opens a frame
      if (b == plp_pkg::START_BYTE) frame_pos = 1;
    end else begin
      frame[frame_pos - 1] = b;
      frame_pos++;
      if (frame_pos == plp_pkg::PACKET_LEN) begin
        frame_pos = 0;
        if (frame[0] >= plp_pkg::INDEX_BASE && frame[0] <= plp_pkg::INDEX_LAST) begin
          emit_points();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      rotation  = plp_pkg::ROT_RESET;
      frame_pos = 0;
      points_due.delete();
    end else begin
      // register port
      if (psel && penable && pready && paddr[2] == plp_pkg::REG_ROTATION) begin
        if (pwrite) begin
          rotation = pwdata[8:0];
        end else if (prdata !== {23'd0, rotation}) begin
          $error("prdata mismatch: expected %0d, got %0d", rotation, prdata);
          mismatches++;
        end
      end
      // reading beat
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $error("reading beat with nothing expected: angle_deg %0d", angle_deg);
          mismatches++;
        end else begin
          p = points_due.pop_front();
          check_field("angle_deg", p.angle, angle_deg);
          check_field("distance", p.dist_mm, distance);
          check_field("range_error", p.err, range_error);
          check_field("strength_warning", p.warn, strength_warning);
          check_field("signal_strength", p.strength, signal_strength);
          check_field("pos_x", p.x, pos_x);
          check_field("pos_y", p.y, pos_y);
          check_field("spin_speed", p.speed, spin_speed);
          check_field("last_of_packet", p.last, last_of_packet);
        end
      end
      // byte beat
      if (in_valid && !in_stall) take_byte(rx_byte);
    end
    readings_pending = points_due.size();
  end

endmodule

### test/lidar_packet_to_points_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_to_points_test
// feeds the packet parser with sensor byte streams under several rotations
// ----------------------------------------------------------------------------
// a short opening packet hits the field extremes, then random packets with
// noise, truncated frames and out-of-range indexes follow in four phases,
// each under its own rotation. the sender runs in bursts, the receiver
// stalls on its own pattern and once holds off long enough to back the
// block up. the checker predicts and compares; this module only drives.
// ----------------------------------------------------------------------------
module lidar_packet_to_points_test;

  localparam int             WATCHDOG_LIMIT = 4000;
  localparam int             TAIL_CYCLES    = 10;
  localparam int             HOLD_CYCLES    = 400;
  localparam logic [2:0]     ROT_ADDR       = {plp_pkg::REG_ROTATION, 2'b00};
  localparam logic [2:0]     SPARE_ADDR     = 3'd4;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;
  logic               in_valid, in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid, out_stall;
  logic [8:0]         angle_deg;
  logic [13:0]        distance;
  logic               range_error, strength_warning;
  logic [15:0]        signal_strength;
  logic signed [14:0] pos_x, pos_y;
  logic [7:0]         spin_speed;
  logic               last_of_packet;
  int                 readings_pending, mismatches;

  // sender burst state, long hold-off request to the receiver
  int   burst_left  = 0;
  int   phase_bytes = 0;
  int   idle_cycles = 0;
  bit   hold_req    = 1'b0;

  // opening stream: a hunting byte, then one packet at the top index with
  // full speed word, maximum distance, both flags with forced-zero
  // distance, a start byte inside the data and full-scale strength
  logic [7:0] opening [0:22] = '{
    8'h55,
    8'hFA, 8'hF9, 8'hFF, 8'hFF,
    8'hFF, 8'h3F, 8'h00, 8'h00,
    8'hFA, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h40, 8'h34, 8'h12,
    8'h10, 8'h27, 8'hFA, 8'h01,
    8'hFA, 8'h00
  };

  always #5 clk = ~clk;

  lidar_packet_to_points u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .angle_deg        (angle_deg),
    .distance         (distance),
    .range_error      (range_error),
    .strength_warning (strength_warning),
    .signal_strength  (signal_strength),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .spin_speed       (spin_speed),
    .last_of_packet   (last_of_packet)
  );

  lidar_packet_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .angle_deg        (angle_deg),
    .distance         (distance),
    .range_error      (range_error),
    .strength_warning (strength_warning),
    .signal_strength  (signal_strength),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .spin_speed       (spin_speed),
    .last_of_packet   (last_of_packet),
    .readings_pending (readings_pending),
    .mismatches       (mismatches)
  );

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: stall pattern is picked anew at random intervals, plus one long
  // hold-off counted here when the stimulus asks for it
  initial begin : receiver
    int mode, mode_left, hold_left, tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_stall <= (tick % 5 < 2);
          end
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 25);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // no beat in flight, then a tail of TAIL_CYCLES for a frame that gives nothing
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (readings_pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // one sensor frame with random content; returns 1 if it should give
  // four readings when it arrives whole
  task automatic send_frame(output bit gives_points);
    logic [7:0] fb [0:21];
    int         pick, i, cut;
    pick = $urandom_range(0, 9);
    case (pick)
      0: fb[1] = plp_pkg::INDEX_BASE;
      1: fb[1] = plp_pkg::INDEX_LAST;
      2: fb[1] = 8'($urandom_range(0, 8'h9F));
      3: fb[1] = 8'($urandom_range(8'hFA, 8'hFF));
      default: fb[1] = 8'($urandom_range(plp_pkg::INDEX_BASE, plp_pkg::INDEX_LAST));
    endcase
    fb[0] = plp_pkg::START_BYTE;
    fb[2] = 8'($urandom);
    fb[3] = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
    for (i = 0; i < plp_pkg::READINGS; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          fb[4 + i * 4] = 8'hFF;
          fb[5 + i * 4] = 8'h3F;
        end
        1: begin
          fb[4 + i * 4] = 8'h00;
          fb[5 + i * 4] = 8'h00;
        end
        default: begin
          fb[4 + i * 4] = 8'($urandom);
          fb[5 + i * 4] = 8'($urandom);
        end
      endcase
      fb[6 + i * 4] = 8'($urandom);
      fb[7 + i * 4] = 8'($urandom);
    end
    fb[20] = 8'($urandom);
    fb[21] = 8'($urandom);
    // broken frame now and then: it swallows the start of the next one
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plp_pkg::PACKET_LEN - 1)
                                      : plp_pkg::PACKET_LEN;
    for (i = 0; i < cut; i++) push_byte(fb[i]);
    gives_points = (cut == plp_pkg::PACKET_LEN) && (fb[1] >= plp_pkg::INDEX_BASE) &&
                   (fb[1] <= plp_pkg::INDEX_LAST);
  endtask

  initial begin : stimulus
    int         phase, good_frames, n, i;
    bit         gives;
    logic [8:0] rot;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    rx_byte  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset value of the rotation, then the opening packet under it
    apb_access(1'b0, ROT_ADDR, 32'd0);
    foreach (opening[k]) push_byte(opening[k]);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: rot = 9'd0;
        1: rot = 9'd359;
        2: rot = 9'd511;   // beyond a full turn, wraps modulo 360
        default: rot = 9'($urandom_range(0, 511));
      endcase
      // upper data bits are don't-care for a 9-bit register
      apb_access(1'b1, ROT_ADDR,
                 {($urandom_range(0, 1) == 1) ? 23'($urandom) : 23'd0, rot});
      // the unused address must leave the rotation alone
      if (phase >= 2) apb_access(1'b1, SPARE_ADDR, $urandom);
      apb_access(1'b0, ROT_ADDR, 32'd0);
      if (phase == 1) hold_req = 1'b1;

      phase_bytes = 0;
      good_frames = 0;
      while ((phase_bytes < 40 || good_frames < 2) && phase_bytes < 120) begin
        // hunting noise between frames, sometimes with a stray start byte
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            push_byte(($urandom_range(0, 3) == 0) ? plp_pkg::START_BYTE : 8'($urandom));
          end
        end
        send_frame(gives);
        if (gives) good_frames++;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
